@@ rtl/core/dpht_pkg.sv @@
// Shared types and constants for the depth-preferred probe hash table.
// Holds the item structs, the table entry layout and the sequencer states.
// No dependencies.
package dpht_pkg;

  // Table size must be a power of two: the home slot is the low key bits.
  localparam int TABLE_ENTRIES = 4096;
  localparam int PROBE_LIMIT   = 8;

  localparam int IDX_W  = $clog2(TABLE_ENTRIES);
  localparam int STEP_W = $clog2(PROBE_LIMIT + 1);

  typedef enum logic [1:0] {
    KIND_LOOKUP = 2'd0,
    KIND_UPDATE = 2'd1,
    KIND_CLEAR  = 2'd2
  } kind_t;

  typedef struct packed {
    logic [1:0]         kind;
    logic [63:0]        key;
    logic signed [31:0] score_in;
    logic [1:0]         bound_kind_in;
    logic [31:0]        best_move_in;
    logic [7:0]         search_depth_in;
  } in_item_t;

  typedef struct packed {
    logic               found;
    logic signed [31:0] score_out;
    logic [1:0]         bound_kind_out;
    logic [31:0]        best_move_out;
    logic [7:0]         search_depth_out;
    logic               written;
  } out_item_t;

  typedef struct packed {
    logic [63:0]        key;
    logic [7:0]         depth;
    logic signed [31:0] score;
    logic [1:0]         bound;
    logic [31:0]        move;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_PROBE,
    ST_SWEEP,
    ST_DONE
  } state_t;

endpackage

@@ rtl/core/dpht_ram.sv @@
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
module dpht_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ rtl/core/depth_preferred_probe_hash_table.sv @@
// Top level of the depth-preferred linear-probe hash table.
// Uses dpht_pkg for types and constants and dpht_ram for the entry store.
//
// All entries live in one RAM of TABLE_ENTRIES words, each holding key, depth,
// score, bound kind and move. A lookup or update reads the probe slots one per
// cycle from the single read port and evaluates each one in the cycle after it
// is read. A lookup stops at a matching key or an empty slot, an update at an
// empty slot or a matching key of lesser depth, both after at most PROBE_LIMIT
// probes; an update that stores writes the chosen slot in the cycle it is
// decided. A clear walks the RAM one entry per cycle. After reset the same
// clearing pass runs over all TABLE_ENTRIES entries before the first item is
// accepted. Lookups with key zero, updates with key zero and kind 3 return an
// all-zero result. One item is in work at a time: the next item can be
// accepted from the cycle in which the result is presented.
module depth_preferred_probe_hash_table (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  dpht_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_stall,
  output dpht_pkg::out_item_t out_item
);

  dpht_pkg::state_t    state_r, state_nxt;
  dpht_pkg::in_item_t  req_r, req_nxt;
  dpht_pkg::out_item_t res_r, res_nxt;
  dpht_pkg::out_item_t out_item_r, out_item_nxt;
  logic                out_valid_r, out_valid_nxt;

  logic [dpht_pkg::STEP_W-1:0] issue_r, issue_nxt;
  logic [dpht_pkg::STEP_W-1:0] rstep_r, rstep_nxt;
  logic                        rvalid_r, rvalid_nxt;
  logic [dpht_pkg::IDX_W-1:0]  rslot_r, rslot_nxt;
  logic [dpht_pkg::IDX_W-1:0]  low_slot_r, low_slot_nxt;
  logic [7:0]                  low_depth_r, low_depth_nxt;
  logic [dpht_pkg::IDX_W-1:0]  sweep_r, sweep_nxt;

  logic                         rd_en, wr_en;
  logic [dpht_pkg::IDX_W-1:0]   rd_addr, wr_addr;
  logic [dpht_pkg::ENTRY_W-1:0] rd_data, wr_data;

  dpht_pkg::entry_t ent, fill;
  logic [7:0]       cur_low_d;
  logic [dpht_pkg::IDX_W-1:0] cur_low_s;
  logic             last_step;
  logic             out_free;

  dpht_ram #(
    .WIDTH (dpht_pkg::ENTRY_W),
    .DEPTH (dpht_pkg::TABLE_ENTRIES)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign in_stall  = (state_r != dpht_pkg::ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= dpht_pkg::ST_INIT;
      out_valid_r <= 1'b0;
      rvalid_r    <= 1'b0;
      sweep_r     <= '0;
      issue_r     <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      rvalid_r    <= rvalid_nxt;
      sweep_r     <= sweep_nxt;
      issue_r     <= issue_nxt;
    end
    req_r       <= req_nxt;
    res_r       <= res_nxt;
    out_item_r  <= out_item_nxt;
    rstep_r     <= rstep_nxt;
    rslot_r     <= rslot_nxt;
    low_slot_r  <= low_slot_nxt;
    low_depth_r <= low_depth_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    req_nxt       = req_r;
    res_nxt       = res_r;
    out_item_nxt  = out_item_r;
    out_valid_nxt = out_valid_r;
    issue_nxt     = issue_r;
    rstep_nxt     = rstep_r;
    rvalid_nxt    = rvalid_r;
    rslot_nxt     = rslot_r;
    low_slot_nxt  = low_slot_r;
    low_depth_nxt = low_depth_r;
    sweep_nxt     = sweep_r;

    ent       = dpht_pkg::entry_t'(rd_data);
    last_step = (rstep_r == dpht_pkg::STEP_W'(dpht_pkg::PROBE_LIMIT - 1));
    cur_low_d = low_depth_r;
    cur_low_s = low_slot_r;

    fill.key   = req_r.key;
    fill.depth = req_r.search_depth_in;
    fill.score = req_r.score_in;
    fill.bound = req_r.bound_kind_in;
    fill.move  = req_r.best_move_in;

    rd_en   = 1'b0;
    rd_addr = dpht_pkg::IDX_W'(req_r.key[dpht_pkg::IDX_W-1:0]
                               + dpht_pkg::IDX_W'(issue_r));
    wr_en   = 1'b0;
    wr_addr = rslot_r;
    wr_data = dpht_pkg::ENTRY_W'(fill);

    out_free = !out_valid_r || !out_stall;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      dpht_pkg::ST_INIT, dpht_pkg::ST_SWEEP: begin
        wr_en     = 1'b1;
        wr_addr   = sweep_r;
        wr_data   = '0;
        sweep_nxt = sweep_r + 1'b1;
        if (sweep_r == dpht_pkg::IDX_W'(dpht_pkg::TABLE_ENTRIES - 1)) begin
          state_nxt = (state_r == dpht_pkg::ST_INIT) ? dpht_pkg::ST_IDLE
                                                     : dpht_pkg::ST_DONE;
        end
      end

      dpht_pkg::ST_IDLE: begin
        if (in_valid) begin
          req_nxt    = in_item;
          res_nxt    = '0;
          issue_nxt  = '0;
          rvalid_nxt = 1'b0;
          sweep_nxt  = '0;
          priority if ((in_item.kind == dpht_pkg::KIND_LOOKUP ||
                        in_item.kind == dpht_pkg::KIND_UPDATE) &&
                       in_item.key != 64'd0) begin
            state_nxt = dpht_pkg::ST_PROBE;
          end else if (in_item.kind == dpht_pkg::KIND_CLEAR) begin
            state_nxt = dpht_pkg::ST_SWEEP;
          end else begin
            state_nxt = dpht_pkg::ST_DONE;
          end
        end
      end

      dpht_pkg::ST_PROBE: begin
        // issue the next probe read while the previous one is evaluated
        if (issue_r < dpht_pkg::STEP_W'(dpht_pkg::PROBE_LIMIT)) begin
          rd_en      = 1'b1;
          rvalid_nxt = 1'b1;
          rstep_nxt  = issue_r;
          rslot_nxt  = rd_addr;
          issue_nxt  = issue_r + 1'b1;
        end else begin
          rvalid_nxt = 1'b0;
        end

        if (rvalid_r) begin
          if (req_r.kind == dpht_pkg::KIND_LOOKUP) begin
            if (ent.key == req_r.key) begin
              res_nxt.found            = 1'b1;
              res_nxt.score_out        = ent.score;
              res_nxt.bound_kind_out   = ent.bound;
              res_nxt.best_move_out    = ent.move;
              res_nxt.search_depth_out = ent.depth;
              state_nxt                = dpht_pkg::ST_DONE;
            end else if (ent.key == 64'd0 || last_step) begin
              state_nxt = dpht_pkg::ST_DONE;
            end
          end else begin
            if (ent.key == 64'd0 ||
                (ent.key == req_r.key && ent.depth < req_r.search_depth_in)) begin
              wr_en           = 1'b1;
              wr_addr         = rslot_r;
              res_nxt.written = 1'b1;
              state_nxt       = dpht_pkg::ST_DONE;
            end else begin
              // home slot seeds the victim; later slots only if strictly shallower
              if (rstep_r == '0 || ent.depth < low_depth_r) begin
                cur_low_d = ent.depth;
                cur_low_s = rslot_r;
              end
              low_depth_nxt = cur_low_d;
              low_slot_nxt  = cur_low_s;
              if (last_step) begin
                if (req_r.search_depth_in > cur_low_d) begin
                  wr_en           = 1'b1;
                  wr_addr         = cur_low_s;
                  res_nxt.written = 1'b1;
                end
                state_nxt = dpht_pkg::ST_DONE;
              end
            end
          end
        end
      end

      dpht_pkg::ST_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_item_nxt  = res_r;
          state_nxt     = dpht_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = dpht_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

@@ bench/depth_preferred_probe_hash_table_test.sv @@
// Testbench for depth_preferred_probe_hash_table: directed, backpressure and random traffic.
// Checks each result against a local model of the probe table. Depends on dpht_pkg and the
// block itself.
module depth_preferred_probe_hash_table_test;

  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam int RANDOM_ITEMS = 1580;
  localparam int POOL_KEYS = 40;
  localparam int WRAP_HOME = dpht_pkg::TABLE_ENTRIES - 3;

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  dpht_pkg::in_item_t in_item;
  logic out_valid;
  logic out_stall;
  dpht_pkg::out_item_t out_item;

  dpht_pkg::entry_t slots [dpht_pkg::TABLE_ENTRIES];
  dpht_pkg::out_item_t expected_results [$];
  logic [63:0] key_pool [POOL_KEYS];
  int mismatches = 0;
  int clears_left = 8;
  int hold_off_len = 0;
  bit sender_gaps_on = 1'b1;
  bit receiver_stalls_on = 1'b1;

  always #2 clk = ~clk;

  depth_preferred_probe_hash_table dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_item(in_item),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_item(out_item)
  );

  // Probe-table model: updates the local copy and returns the result for one item.
  function automatic dpht_pkg::out_item_t table_access(dpht_pkg::in_item_t it);
    dpht_pkg::out_item_t r;
    logic [dpht_pkg::IDX_W-1:0] home, s, low_slot, target;
    logic [7:0] low_depth;
    bit done, store;
    r = '0;
    done = 1'b0;
    store = 1'b0;
    target = '0;
    home = it.key[dpht_pkg::IDX_W-1:0];
    if (it.kind == dpht_pkg::KIND_LOOKUP && it.key != 64'd0) begin
      for (int i = 0; i < dpht_pkg::PROBE_LIMIT && !done; i++) begin
        s = home + dpht_pkg::IDX_W'(i);
        if (slots[s].key == it.key) begin
          r.found = 1'b1;
          r.score_out = slots[s].score;
          r.bound_kind_out = slots[s].bound;
          r.best_move_out = slots[s].move;
          r.search_depth_out = slots[s].depth;
          done = 1'b1;
        end else if (slots[s].key == 64'd0) begin
          done = 1'b1;
        end
      end
    end else if (it.kind == dpht_pkg::KIND_UPDATE && it.key != 64'd0) begin
      low_slot = home;
      low_depth = slots[home].depth;
      for (int i = 0; i < dpht_pkg::PROBE_LIMIT && !done; i++) begin
        s = home + dpht_pkg::IDX_W'(i);
        if (slots[s].key == 64'd0 ||
            (slots[s].key == it.key && slots[s].depth < it.search_depth_in)) begin
          target = s;
          store = 1'b1;
          done = 1'b1;
        end else if (slots[s].depth < low_depth) begin
          // ties keep the earlier slot
          low_depth = slots[s].depth;
          low_slot = s;
        end
      end
      if (!done && it.search_depth_in > low_depth) begin
        target = low_slot;
        store = 1'b1;
      end
      if (store)
        slots[target] = {it.key, it.search_depth_in, it.score_in, it.bound_kind_in,
                         it.best_move_in};
      r.written = store;
    end else if (it.kind == dpht_pkg::KIND_CLEAR) begin
      foreach (slots[j]) begin
        slots[j].key = '0;
        slots[j].depth = '0;
      end
    end
    return r;
  endfunction

  function automatic dpht_pkg::in_item_t make_item(logic [1:0] kind, logic [63:0] key,
                                                   logic signed [31:0] score,
                                                   logic [1:0] bound,
                                                   logic [31:0] move, logic [7:0] depth);
    dpht_pkg::in_item_t it;
    it.kind = kind;
    it.key = key;
    it.score_in = score;
    it.bound_kind_in = bound;
    it.best_move_in = move;
    it.search_depth_in = depth;
    return it;
  endfunction

  function automatic int input_gap();
    int r;
    if (!sender_gaps_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(5, 40);
  endfunction

  // Leaves in_valid high after acceptance so back-to-back items need no gap.
  task automatic send_item(input dpht_pkg::in_item_t it);
    int gap;
    gap = input_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_results.push_back(table_access(it));
  endtask

  task automatic wait_for_results();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (dpht_pkg::PROBE_LIMIT + 4) @(posedge clk);
  endtask

  task automatic compare_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : result_check
    dpht_pkg::out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        $display("%0t: result with none expected, got %0h", $time, out_item);
        mismatches++;
      end else begin
        want = expected_results.pop_front();
        compare_field("found", 64'(want.found), 64'(out_item.found));
        compare_field("score_out", 64'(want.score_out), 64'(out_item.score_out));
        compare_field("bound_kind_out", 64'(want.bound_kind_out),
                      64'(out_item.bound_kind_out));
        compare_field("best_move_out", 64'(want.best_move_out),
                      64'(out_item.best_move_out));
        compare_field("search_depth_out", 64'(want.search_depth_out),
                      64'(out_item.search_depth_out));
        compare_field("written", 64'(want.written), 64'(out_item.written));
      end
    end
  end

  // Result side stall pattern; a requested hold-off is counted here.
  initial begin : result_receiver
    int n;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_len > 0) begin
        n = hold_off_len;
        hold_off_len = 0;
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end else if (!receiver_stalls_on) begin
        out_stall <= 1'b0;
      end else if ($urandom_range(0, 199) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(10, 60)) @(posedge clk);
      end else begin
        out_stall <= ($urandom_range(0, 99) < 25);
      end
    end
  end

  // Keys clustered on a dozen neighboring home slots so probe chains fill and overlap.
  task automatic refill_key_pool();
    int base;
    logic [63:0] k;
    base = $urandom_range(0, 1) ? dpht_pkg::TABLE_ENTRIES - 6
                                : $urandom_range(0, dpht_pkg::TABLE_ENTRIES - 1);
    for (int i = 0; i < POOL_KEYS; i++) begin
      k = {$urandom, $urandom};
      k[dpht_pkg::IDX_W-1:0] = dpht_pkg::IDX_W'(base + $urandom_range(0, 11));
      if (k == 64'd0) k = 64'd1;
      key_pool[i] = k;
    end
  endtask

  function automatic dpht_pkg::in_item_t random_item();
    dpht_pkg::in_item_t it;
    int r;
    it = make_item(dpht_pkg::KIND_LOOKUP, key_pool[$urandom_range(0, POOL_KEYS - 1)],
                   $urandom, 2'($urandom_range(0, 3)), $urandom,
                   8'($urandom_range(0, 255)));
    r = $urandom_range(0, 999);
    if (r < 450) begin
      it.kind = dpht_pkg::KIND_LOOKUP;
    end else if (r < 920) begin
      it.kind = dpht_pkg::KIND_UPDATE;
    end else if (r < 940) begin
      it.kind = KIND_UNUSED;
    end else if (r < 975) begin
      it.kind = (r < 960) ? dpht_pkg::KIND_LOOKUP : dpht_pkg::KIND_UPDATE;
      it.key = '0;
    end else if (r < 995 || clears_left == 0) begin
      it.kind = $urandom_range(0, 1) ? dpht_pkg::KIND_UPDATE : dpht_pkg::KIND_LOOKUP;
      it.key = {$urandom, $urandom};
    end else begin
      it.kind = dpht_pkg::KIND_CLEAR;
      clears_left--;
    end
    return it;
  endfunction

  function automatic logic [63:0] chain_key(int n);
    return (64'(n + 1) << dpht_pkg::IDX_W) | 64'(WRAP_HOME);
  endfunction

  // All chain keys share the home slot TABLE_ENTRIES - 3, so the probe wraps to slot 0.
  task automatic test_directed_cases();
    send_item(make_item(dpht_pkg::KIND_LOOKUP, chain_key(0), '0, '0, '0, '0));
    send_item(make_item(dpht_pkg::KIND_LOOKUP, 64'd0, '0, '0, '0, '0));
    send_item(make_item(dpht_pkg::KIND_UPDATE, 64'd0, 32'sd77, 2'd1, 32'h1234, 8'd9));
    send_item(make_item(KIND_UNUSED, chain_key(3), 32'sd5, 2'd2, 32'h55, 8'd7));
    send_item(make_item(dpht_pkg::KIND_UPDATE, chain_key(0), 32'sh8000_0000, 2'd0,
                        32'h0, 8'd10));
    send_item(make_item(dpht_pkg::KIND_UPDATE, chain_key(1), 32'sh7fff_ffff, 2'd3,
                        32'hffff_ffff, 8'd5));
    send_item(make_item(dpht_pkg::KIND_UPDATE, chain_key(2), -32'sd1, 2'd1,
                        32'h8000_0001, 8'd20));
    send_item(make_item(dpht_pkg::KIND_UPDATE, chain_key(3), 32'sd1, 2'd2,
                        32'h0000_ffff, 8'd5));
    send_item(make_item(dpht_pkg::KIND_UPDATE, chain_key(4), 32'sd300, 2'd0,
                        32'hdead_beef, 8'd30));
    send_item(make_item(dpht_pkg::KIND_UPDATE, chain_key(5), -32'sd300, 2'd3,
                        32'h0f0f_0f0f, 8'd40));
    send_item(make_item(dpht_pkg::KIND_UPDATE, chain_key(6), 32'sd42, 2'd1,
                        32'hf0f0_f0f0, 8'd50));
    send_item(make_item(dpht_pkg::KIND_UPDATE, chain_key(7), 32'sd43, 2'd2,
                        32'h1357_9bdf, 8'd60));
    // matching key not deeper, full probe, new depth not greater: dropped
    send_item(make_item(dpht_pkg::KIND_UPDATE, chain_key(1), 32'sd9, 2'd0, 32'h9, 8'd3));
    // shallowest tie between two slots of depth 5: the earlier one is replaced
    send_item(make_item(dpht_pkg::KIND_UPDATE, chain_key(8), 32'sh8000_0000, 2'd3,
                        32'hffff_ffff, 8'd6));
    send_item(make_item(dpht_pkg::KIND_LOOKUP, chain_key(1), '0, '0, '0, '0));
    send_item(make_item(dpht_pkg::KIND_LOOKUP, chain_key(8), '0, '0, '0, '0));
    send_item(make_item(dpht_pkg::KIND_UPDATE, chain_key(8), 32'sh7fff_ffff, 2'd0,
                        32'h0, 8'd255));
    send_item(make_item(dpht_pkg::KIND_LOOKUP, chain_key(8), '0, '0, '0, '0));
    send_item(make_item(dpht_pkg::KIND_UPDATE, chain_key(8), 32'sd11, 2'd1, 32'h11,
                        8'd255));
    send_item(make_item(dpht_pkg::KIND_LOOKUP, chain_key(3), '0, '0, '0, '0));
    send_item(make_item(dpht_pkg::KIND_CLEAR, 64'd0, '0, '0, '0, '0));
    send_item(make_item(dpht_pkg::KIND_LOOKUP, chain_key(0), '0, '0, '0, '0));
    send_item(make_item(dpht_pkg::KIND_UPDATE, 64'hffff_ffff_ffff_ffff, -32'sd2, 2'd3,
                        32'h7, 8'd0));
    send_item(make_item(dpht_pkg::KIND_LOOKUP, 64'hffff_ffff_ffff_ffff, '0, '0, '0, '0));
    wait_for_results();
  endtask

  // Receiver holds off while the sender keeps offering, so the input stalls.
  task automatic test_backpressure();
    refill_key_pool();
    sender_gaps_on = 1'b0;
    receiver_stalls_on = 1'b0;
    hold_off_len = 300;
    for (int n = 0; n < 12; n++) send_item(random_item());
    wait_for_results();
    sender_gaps_on = 1'b1;
    receiver_stalls_on = 1'b1;
  endtask

  task automatic test_random_traffic();
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 300 == 0) refill_key_pool();
      if (n % 120 == 0) begin
        sender_gaps_on = ($urandom_range(0, 3) != 0);
        receiver_stalls_on = ($urandom_range(0, 3) != 0);
      end
      send_item(random_item());
    end
    wait_for_results();
  endtask

  initial begin
    foreach (slots[j]) slots[j] = '0;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_item <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_cases();
    test_backpressure();
    test_random_traffic();
    if (mismatches == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

  initial begin
    #4_500_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

@@ sim.f @@
rtl/core/dpht_pkg.sv
rtl/core/dpht_ram.sv
rtl/core/depth_preferred_probe_hash_table.sv
bench/depth_preferred_probe_hash_table_test.sv
